// ----- design/hsv_pkg.sv -----
// package for the hsv to rgb converter: widths, hue constants, sector codes
package hsv_pkg;

   localparam int HUE_BITS             = 12;
   localparam int RAMP_BITS            = 10;
   localparam int DEFAULT_CHANNEL_BITS = 8;

   localparam logic [HUE_BITS-1:0]  HUE_TURN   = 12'd3600;
   localparam logic [RAMP_BITS-1:0] HUE_SECTOR = 10'd600;
   localparam logic [RAMP_BITS-1:0] HUE_HALF   = 10'd300;

   // 60-degree sectors, named by the channel holding chroma then the one holding the ramp
   typedef enum logic [2:0] {
      SECT_RG = 3'd0,
      SECT_GR = 3'd1,
      SECT_GB = 3'd2,
      SECT_BG = 3'd3,
      SECT_BR = 3'd4,
      SECT_RB = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type           sector;
      logic [RAMP_BITS-1:0] ramp;
   } sector_info_type;

endpackage

// ----- design/hsv_sector_decode.sv -----
// hue wrap, 60-degree sector search and ramp within the sector
module hsv_sector_decode
   import hsv_pkg::*;
(
   input  logic [HUE_BITS-1:0] hue,
   output sector_info_type     info
);

   logic [HUE_BITS-1:0]  hue_wrap;
   logic [HUE_BITS-1:0]  base;
   logic [HUE_BITS-1:0]  offset;
   logic [RAMP_BITS-1:0] pos;
   sector_type           sector;

   always_comb begin
      hue_wrap = (hue >= HUE_TURN) ? (hue - HUE_TURN) : hue;
      if (hue_wrap < 12'd600) begin
         sector = SECT_RG;
         base   = 12'd0;
      end else if (hue_wrap < 12'd1200) begin
         sector = SECT_GR;
         base   = 12'd600;
      end else if (hue_wrap < 12'd1800) begin
         sector = SECT_GB;
         base   = 12'd1200;
      end else if (hue_wrap < 12'd2400) begin
         sector = SECT_BG;
         base   = 12'd1800;
      end else if (hue_wrap < 12'd3000) begin
         sector = SECT_BR;
         base   = 12'd2400;
      end else begin
         sector = SECT_RB;
         base   = 12'd3000;
      end
      offset = hue_wrap - base;
      pos    = offset[RAMP_BITS-1:0];
      info.sector = sector;
      // odd sectors ramp down
      info.ramp   = sector[0] ? (HUE_SECTOR - pos) : pos;
   end

endmodule

// ----- design/hsv_to_rgb_converter_top.sv -----
// hsv to rgb converter top level: six-stage pipeline with per-stage flow control
// the stages are sector/v*s, chroma, c*ramp, reciprocal multiply, divide-by-600
//   correction, channel assembly; throughput: one transfer per cycle unless
//   rsp_stall holds a result; each stage holds only while the next is full and
//   stalled, so bubbles squeeze out and a waiting result does not block input
// reset: synchronous active-high reset clears the stage valid bits only
module hsv_to_rgb_converter_top
   import hsv_pkg::*;
#(
   parameter int CHANNEL_BITS = DEFAULT_CHANNEL_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [HUE_BITS-1:0]     req_hue,
   input  logic [CHANNEL_BITS-1:0] req_saturation,
   input  logic [CHANNEL_BITS-1:0] req_brightness,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CHANNEL_BITS-1:0] rsp_red,
   output logic [CHANNEL_BITS-1:0] rsp_green,
   output logic [CHANNEL_BITS-1:0] rsp_blue
);

   localparam int N   = CHANNEL_BITS;
   localparam int PW  = N + RAMP_BITS;      // c*ramp+300 width
   localparam int ZW  = PW - 3;             // after the divide by 8 of 600 = 8*75
   localparam int SH  = ZW + 7;             // reciprocal scale, 2^SH / 75
   localparam int KW  = ZW + 1;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << SH) / 64'd75;
   localparam logic [KW-1:0] RECIP = RECIP_WIDE[KW-1:0];
   localparam logic [2*N-1:0] ROUND_HALF = (2*N)'((64'd1 << (N - 1)) - 64'd1);
   localparam logic [N:0] FULL = (N+1)'((64'd1 << N) - 64'd1);

   // flow control: a stage loads when it is empty or the next one moves
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, out_ready;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s5_ready  = !s5_valid_ff || out_ready;
   assign s4_ready  = !s4_valid_ff || s5_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_valid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (s4_ready)  s4_valid_ff  <= s3_valid_ff;
         if (s5_ready)  s5_valid_ff  <= s4_valid_ff;
         if (out_ready) rsp_valid_ff <= s5_valid_ff;
      end
   end

   // stage 1: sector and ramp from hue, v*s product
   sector_info_type  s1_info_in, s1_info_ff;
   logic [2*N-1:0]   s1_vs_in, s1_vs_ff;
   logic [N-1:0]     s1_val_ff;

   hsv_sector_decode u_sector (
      .hue  (req_hue),
      .info (s1_info_in)
   );

   assign s1_vs_in = (2*N)'(req_brightness) * (2*N)'(req_saturation);

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_info_ff <= s1_info_in;
         s1_vs_ff   <= s1_vs_in;
         s1_val_ff  <= req_brightness;
      end
   end

   // stage 2: chroma = round(v*s / full), exact via (y + 1 + (y >> n)) >> n
   logic [2*N-1:0] s2_y;
   logic [2*N:0]   s2_sum;
   logic [N-1:0]   s2_c_in, s2_c_ff, s2_val_ff;
   sector_info_type s2_info_ff;

   assign s2_y    = s1_vs_ff + ROUND_HALF;
   assign s2_sum  = (2*N+1)'(s2_y) + (2*N+1)'(s2_y >> N) + (2*N+1)'(1);
   assign s2_c_in = s2_sum[2*N-1:N];

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_c_ff    <= s2_c_in;
         s2_val_ff  <= s1_val_ff;
         s2_info_ff <= s1_info_ff;
      end
   end

   // stage 3: c*ramp + 300, pre-divided by 8; offset m = v - c
   logic [PW-1:0] s3_prod;
   logic [ZW-1:0] s3_z_in, s3_z_ff;
   logic [N-1:0]  s3_c_ff, s3_m_ff;
   sector_type    s3_sector_ff;

   assign s3_prod = PW'(s2_c_ff) * PW'(s2_info_ff.ramp) + PW'(HUE_HALF);
   assign s3_z_in = s3_prod[PW-1:3];

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_z_ff      <= s3_z_in;
         s3_c_ff      <= s2_c_ff;
         s3_m_ff      <= s2_val_ff - s2_c_ff;
         s3_sector_ff <= s2_info_ff.sector;
      end
   end

   // stage 4: reciprocal multiply for the divide by 75
   logic [2*ZW:0] s4_zk_ff;
   logic [ZW-1:0] s4_z_ff;
   logic [N-1:0]  s4_c_ff, s4_m_ff;
   sector_type    s4_sector_ff;

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_zk_ff     <= (2*ZW+1)'(s3_z_ff) * (2*ZW+1)'(RECIP);
         s4_z_ff      <= s3_z_ff;
         s4_c_ff      <= s3_c_ff;
         s4_m_ff      <= s3_m_ff;
         s4_sector_ff <= s3_sector_ff;
      end
   end

   // stage 5: estimate is exact or one low; fix with one remainder compare
   logic [N-1:0]  s5_q0;
   logic [ZW-1:0] s5_rem;
   logic [N-1:0]  s5_x_in, s5_x_ff, s5_c_ff, s5_m_ff;
   sector_type    s5_sector_ff;

   assign s5_q0   = s4_zk_ff[SH+N-1:SH];
   assign s5_rem  = s4_z_ff - ZW'(s5_q0) * ZW'(75);
   assign s5_x_in = (s5_rem >= ZW'(75)) ? (s5_q0 + N'(1)) : s5_q0;

   always_ff @(posedge clock) begin
      if (s5_ready) begin
         s5_x_ff      <= s5_x_in;
         s5_c_ff      <= s4_c_ff;
         s5_m_ff      <= s4_m_ff;
         s5_sector_ff <= s4_sector_ff;
      end
   end

   // stage 6: route c and x by sector, add offset, clamp to full scale
   logic [N-1:0] r_sel, g_sel, b_sel;
   logic [N:0]   r_sum, g_sum, b_sum;
   logic [N-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   always_comb begin
      case (s5_sector_ff)
         SECT_RG: begin r_sel = s5_c_ff; g_sel = s5_x_ff; b_sel = '0;      end
         SECT_GR: begin r_sel = s5_x_ff; g_sel = s5_c_ff; b_sel = '0;      end
         SECT_GB: begin r_sel = '0;      g_sel = s5_c_ff; b_sel = s5_x_ff; end
         SECT_BG: begin r_sel = '0;      g_sel = s5_x_ff; b_sel = s5_c_ff; end
         SECT_BR: begin r_sel = s5_x_ff; g_sel = '0;      b_sel = s5_c_ff; end
         default: begin r_sel = s5_c_ff; g_sel = '0;      b_sel = s5_x_ff; end
      endcase
      r_sum = (N+1)'(r_sel) + (N+1)'(s5_m_ff);
      g_sum = (N+1)'(g_sel) + (N+1)'(s5_m_ff);
      b_sum = (N+1)'(b_sel) + (N+1)'(s5_m_ff);
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_red_ff   <= (r_sum > FULL) ? FULL[N-1:0] : r_sum[N-1:0];
         rsp_green_ff <= (g_sum > FULL) ? FULL[N-1:0] : g_sum[N-1:0];
         rsp_blue_ff  <= (b_sum > FULL) ? FULL[N-1:0] : b_sum[N-1:0];
      end
   end

   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

endmodule

// ----- dv/tb.sv -----
// testbench for the hsv to rgb converter: random flow control, per-field result checks
module tb;
   import hsv_pkg::*;

   localparam int CB = DEFAULT_CHANNEL_BITS;
   localparam logic [CB-1:0] CHAN_FULL = '1;
   localparam int RANDOM_PIXELS = 500;
   // worst case is far below this: ~530 pixels, each with long gaps and long stalls
   localparam int CYCLE_LIMIT = 200000;
   // pipeline is six deep, give it a margin to show any stray result
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [HUE_BITS-1:0] hue;
      logic [CB-1:0]       saturation;
      logic [CB-1:0]       brightness;
   } hsv_pixel_type;

   typedef struct packed {
      logic [CB-1:0] red;
      logic [CB-1:0] green;
      logic [CB-1:0] blue;
   } rgb_color_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [HUE_BITS-1:0] req_hue = '0;
   logic [CB-1:0]       req_saturation = '0;
   logic [CB-1:0]       req_brightness = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CB-1:0]       rsp_red;
   logic [CB-1:0]       rsp_green;
   logic [CB-1:0]       rsp_blue;

   hsv_pixel_type pending_pixels[$];
   rgb_color_type expected_colors[$];
   int       pixel_total = 0;
   int       checked_count = 0;
   int       error_count = 0;
   int       cycle_count = 0;

   // high after a rising edge at which the request channel moved a transfer
   logic        req_taken = 1'b0;
   int unsigned req_gap = 0;
   bit          req_burst = 1'b0;
   int unsigned stall_left = 0;
   bit          rsp_burst = 1'b0;

   hsv_to_rgb_converter_top #(
      .CHANNEL_BITS(CB)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // expected color of one pixel, fixed point throughout
   function automatic rgb_color_type convert_pixel(hsv_pixel_type pix);
      logic [HUE_BITS-1:0]      angle;
      logic [2:0]               sect_idx;
      sector_type               sector;
      logic [RAMP_BITS-1:0]     pos;
      logic [RAMP_BITS-1:0]     ramp;
      logic [2*CB:0]            sv_prod;
      logic [CB+RAMP_BITS:0]    ramp_prod;
      logic [CB-1:0]            chroma;
      logic [CB-1:0]            second;
      logic [CB-1:0]            offset;
      logic [CB-1:0]            chan[3];
      logic [CB:0]              sum;
      rgb_color_type            color;
      // out-of-range hue wraps once around the circle
      angle = (pix.hue >= HUE_TURN) ? pix.hue - HUE_TURN : pix.hue;
      sect_idx = 3'(angle / HUE_SECTOR);
      sector = sector_type'(sect_idx);
      pos = RAMP_BITS'(angle - sect_idx * HUE_SECTOR);
      // rising ramp in even sectors, falling in odd ones
      ramp = sect_idx[0] ? HUE_SECTOR - pos : pos;
      // chroma = v*s rounded to nearest
      sv_prod = pix.brightness * pix.saturation + CHAN_FULL / 2;
      chroma = CB'(sv_prod / CHAN_FULL);
      // secondary = chroma*ramp/600, ties round up
      ramp_prod = chroma * ramp + HUE_HALF;
      second = CB'(ramp_prod / HUE_SECTOR);
      offset = pix.brightness - chroma;
      case (sector)
         SECT_RG: begin
            chan[0] = chroma; chan[1] = second; chan[2] = '0;
         end
         SECT_GR: begin
            chan[0] = second; chan[1] = chroma; chan[2] = '0;
         end
         SECT_GB: begin
            chan[0] = '0;     chan[1] = chroma; chan[2] = second;
         end
         SECT_BG: begin
            chan[0] = '0;     chan[1] = second; chan[2] = chroma;
         end
         SECT_BR: begin
            chan[0] = second; chan[1] = '0;     chan[2] = chroma;
         end
         default: begin
            chan[0] = chroma; chan[1] = '0;     chan[2] = second;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         sum = chan[i] + offset;
         chan[i] = (sum > CHAN_FULL) ? CHAN_FULL : sum[CB-1:0];
      end
      color.red = chan[0];
      color.green = chan[1];
      color.blue = chan[2];
      return color;
   endfunction

   // mostly short gaps, a few long ones, none at all inside a burst stretch
   function automatic int unsigned pick_gap(bit no_gaps);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 55) return 0;
      else if (roll < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // fractions lean toward the extremes now and then
   function automatic logic [CB-1:0] pick_fraction();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      else if (roll == 1) return CHAN_FULL;
      else return CB'($urandom_range(0, CHAN_FULL));
   endfunction

   task automatic queue_pixel(logic [HUE_BITS-1:0] h, logic [CB-1:0] s, logic [CB-1:0] v);
      hsv_pixel_type pix;
      pix.hue = h;
      pix.saturation = s;
      pix.brightness = v;
      pending_pixels.push_back(pix);
      pixel_total++;
   endtask

   task automatic check_channel(string name, logic [CB-1:0] want, logic [CB-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // request driver: new payload at the falling edge, held while the block stalls
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled transfer, payload stays put
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_pixels.size() > 0) begin
         req_hue <= pending_pixels[0].hue;
         req_saturation <= pending_pixels[0].saturation;
         req_brightness <= pending_pixels[0].brightness;
         void'(pending_pixels.pop_front());
         req_valid <= 1'b1;
         req_gap <= pick_gap(req_burst);
         if ($urandom_range(0, 39) == 0) req_burst <= ~req_burst;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result-side back pressure, independent of whether a result is waiting
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!rsp_burst && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= pick_gap(1'b0);
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 59) == 0) rsp_burst <= ~rsp_burst;
      end
   end

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      rgb_color_type want;
      hsv_pixel_type pix;
      cycle_count++;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         // check the result before recording this edge's request transfer
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual r %0d g %0d b %0d",
                        $time, rsp_red, rsp_green, rsp_blue);
            end else begin
               want = expected_colors.pop_front();
               checked_count++;
               check_channel("red", want.red, rsp_red);
               check_channel("green", want.green, rsp_green);
               check_channel("blue", want.blue, rsp_blue);
            end
         end
         if (req_valid && !req_stall) begin
            pix.hue = req_hue;
            pix.saturation = req_saturation;
            pix.brightness = req_brightness;
            expected_colors.push_back(convert_pixel(pix));
         end
         req_taken <= req_valid && !req_stall;
      end
   end

   initial begin
      // directed pixels: sector edges, primaries, grays, ties and hue wrap
      queue_pixel(12'd0,    8'd255, 8'd255);
      queue_pixel(12'd1,    8'd255, 8'd255);
      queue_pixel(12'd300,  8'd255, 8'd255);
      queue_pixel(12'd599,  8'd255, 8'd255);
      queue_pixel(12'd600,  8'd255, 8'd255);
      queue_pixel(12'd900,  8'd255, 8'd128);
      queue_pixel(12'd1199, 8'd255, 8'd255);
      queue_pixel(12'd1200, 8'd255, 8'd255);
      queue_pixel(12'd1500, 8'd128, 8'd255);
      queue_pixel(12'd1800, 8'd255, 8'd255);
      queue_pixel(12'd2400, 8'd255, 8'd255);
      queue_pixel(12'd2700, 8'd1,   8'd1);
      queue_pixel(12'd3000, 8'd255, 8'd255);
      queue_pixel(12'd3300, 8'd254, 8'd254);
      queue_pixel(12'd3599, 8'd255, 8'd255);
      queue_pixel(12'd3600, 8'd255, 8'd255);
      queue_pixel(12'd4000, 8'd170, 8'd85);
      queue_pixel(12'd4095, 8'd255, 8'd255);
      queue_pixel(12'd2000, 8'd0,   8'd200);
      queue_pixel(12'd1000, 8'd255, 8'd0);
      queue_pixel(12'd0,    8'd0,   8'd0);
      queue_pixel(12'd0,    8'd0,   8'd255);
      queue_pixel(12'h555,  8'hAA,  8'h55);
      queue_pixel(12'hAAA,  8'h55,  8'hAA);
      // random pixels, a fifth of them across the whole hue field
      repeat (RANDOM_PIXELS) begin
         queue_pixel(HUE_BITS'(($urandom_range(0, 4) == 0)
                               ? $urandom_range(0, 4095)
                               : $urandom_range(0, HUE_TURN - 1)),
                     pick_fraction(), pick_fraction());
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // counters move only at the rising edge, so look at them at the falling one
      while (checked_count < pixel_total && cycle_count < CYCLE_LIMIT) @(negedge clock);
      if (checked_count < pixel_total) begin
         error_count++;
         $display("%0t: timeout, expected %0d results, actual %0d",
                  $time, pixel_total, checked_count);
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
      end
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/hsv_pkg.sv
design/hsv_sector_decode.sv
design/hsv_to_rgb_converter_top.sv
dv/tb.sv
